### hw/rtl/rmq_pkg.sv
`default_nettype none
package rmq_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC       = DATA_WIDTH - 2;
    // Width of the estimates and of the off-diagonal sums and differences.
    localparam int VW         = DATA_WIDTH + 4;
    localparam int MSBW       = $clog2(VW);
    // The largest normalized magnitude lies in [2^29, 2^30).
    localparam int NW         = 30;
    localparam int NORM_MSB   = NW - 1;
    // Square root: two result bits per stage.
    localparam int SQ_STEPS   = NW + 2;
    localparam int SQ_STAGES  = SQ_STEPS / 2;
    localparam int SQ_IN      = 2 * SQ_STEPS;
    localparam int SQ_REMW    = SQ_STEPS + 4;
    localparam int NRW        = NW + 1;
    // Division: two quotient bits per stage.
    localparam int QP         = DATA_WIDTH + (DATA_WIDTH % 2);
    localparam int DIV_STAGES = QP / 2;
    localparam int NUMW       = NW + FRAC + 1;
    localparam int DREMW      = NRW + 1;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] m00;
        logic signed [DATA_WIDTH-1:0] m01;
        logic signed [DATA_WIDTH-1:0] m02;
        logic signed [DATA_WIDTH-1:0] m10;
        logic signed [DATA_WIDTH-1:0] m11;
        logic signed [DATA_WIDTH-1:0] m12;
        logic signed [DATA_WIDTH-1:0] m20;
        logic signed [DATA_WIDTH-1:0] m21;
        logic signed [DATA_WIDTH-1:0] m22;
    } t_in;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] qx;
        logic signed [DATA_WIDTH-1:0] qy;
        logic signed [DATA_WIDTH-1:0] qz;
        logic signed [DATA_WIDTH-1:0] qw;
        logic                         invalid;
    } t_out;

    typedef logic [3:0][NW-1:0] t_lanes;
    typedef logic [3:0][QP-1:0] t_quo;

endpackage
`default_nettype wire

### hw/rtl/rmq_isqrt.sv
`default_nettype none
module rmq_isqrt (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [rmq_pkg::SQ_IN-1:0]  i_s,
    output logic [rmq_pkg::NRW-1:0]    o_root
);
    import rmq_pkg::*;

    logic [SQ_IN-1:0]    r_s    [SQ_STAGES];
    logic [SQ_REMW-1:0]  r_rem  [SQ_STAGES];
    logic [SQ_STEPS-1:0] r_root [SQ_STAGES];
    logic [SQ_IN-1:0]    n_s    [SQ_STAGES];
    logic [SQ_REMW-1:0]  n_rem  [SQ_STAGES];
    logic [SQ_STEPS-1:0] n_root [SQ_STAGES];

    always_comb begin
        logic [SQ_IN-1:0]    s;
        logic [SQ_REMW-1:0]  rem;
        logic [SQ_REMW-1:0]  t;
        logic [SQ_STEPS-1:0] root;
        for (int j = 0; j < SQ_STAGES; j++) begin
            if (j == 0) begin
                s    = i_s;
                rem  = '0;
                root = '0;
            end else begin
                s    = r_s[(j == 0) ? 0 : j - 1];
                rem  = r_rem[(j == 0) ? 0 : j - 1];
                root = r_root[(j == 0) ? 0 : j - 1];
            end
            for (int b = 0; b < 2; b++) begin
                rem = {rem[SQ_REMW-3:0], s[SQ_IN-1 -: 2]};
                s   = {s[SQ_IN-3:0], 2'b00};
                t   = SQ_REMW'({root, 2'b01});
                if (rem >= t) begin
                    rem  = rem - t;
                    root = {root[SQ_STEPS-2:0], 1'b1};
                end else begin
                    root = {root[SQ_STEPS-2:0], 1'b0};
                end
            end
            n_s[j]    = s;
            n_rem[j]  = rem;
            n_root[j] = root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s    <= n_s;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_root = r_root[SQ_STAGES-1][NRW-1:0];

endmodule
`default_nettype wire

### hw/rtl/rmq_div.sv
`default_nettype none
module rmq_div (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  rmq_pkg::t_lanes          i_a,
    input  logic [rmq_pkg::NRW-1:0]  i_n,
    output rmq_pkg::t_quo            o_q
);
    import rmq_pkg::*;

    logic [3:0][DREMW-1:0] r_rem [DIV_STAGES];
    logic [3:0][QP-1:0]    r_low [DIV_STAGES];
    logic [3:0][QP-1:0]    r_q   [DIV_STAGES];
    logic [NRW-1:0]        r_n   [DIV_STAGES];
    logic [3:0][DREMW-1:0] n_rem [DIV_STAGES];
    logic [3:0][QP-1:0]    n_low [DIV_STAGES];
    logic [3:0][QP-1:0]    n_q   [DIV_STAGES];
    logic [NRW-1:0]        n_n   [DIV_STAGES];

    always_comb begin
        logic [NUMW-1:0]  num;
        logic [DREMW-1:0] rem;
        logic [QP-1:0]    low;
        logic [QP-1:0]    q;
        logic [NRW-1:0]   d;
        for (int j = 0; j < DIV_STAGES; j++) begin
            d = (j == 0) ? i_n : r_n[(j == 0) ? 0 : j - 1];
            n_n[j] = d;
            for (int l = 0; l < 4; l++) begin
                if (j == 0) begin
                    // Rounding half up: add half the divisor before dividing.
                    num = {1'b0, i_a[l], FRAC'(0)} + NUMW'(i_n >> 1);
                    rem = DREMW'(num >> QP);
                    low = num[QP-1:0];
                    q   = '0;
                end else begin
                    rem = r_rem[(j == 0) ? 0 : j - 1][l];
                    low = r_low[(j == 0) ? 0 : j - 1][l];
                    q   = r_q[(j == 0) ? 0 : j - 1][l];
                end
                for (int b = 0; b < 2; b++) begin
                    rem = {rem[DREMW-2:0], low[QP-1]};
                    low = {low[QP-2:0], 1'b0};
                    if (rem >= DREMW'(d)) begin
                        rem = rem - DREMW'(d);
                        q   = {q[QP-2:0], 1'b1};
                    end else begin
                        q   = {q[QP-2:0], 1'b0};
                    end
                end
                n_rem[j][l] = rem;
                n_low[j][l] = low;
                n_q[j][l]   = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_low <= n_low;
            r_q   <= n_q;
            r_n   <= n_n;
        end
    end

    assign o_q = r_q[DIV_STAGES-1];

endmodule
`default_nettype wire

### hw/rtl/rotation_matrix_to_quaternion.sv
`default_nettype none
// Channel  Direction  Handshake                     Payload
// input    in         i_in_valid / o_in_ready       i_in_data  (t_in, m00..m22)
// output   out        o_out_valid / i_out_ready     o_out_data (t_out, qx..qw, invalid)
//
// One matrix is taken per cycle while the pipeline is not held; each result passes
// through the front stages, the two-bit-per-stage square root and divider
// pipelines and the output register. Reset clears only the valid bits.
// When the output register holds a result that is not taken, the whole pipeline
// holds and the input is not ready; nothing is dropped or repeated.
module rotation_matrix_to_quaternion (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rmq_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rmq_pkg::t_out o_out_data
);
    import rmq_pkg::*;

    localparam int DW   = DATA_WIDTH;
    localparam int DLY2 = SQ_STAGES + DIV_STAGES;
    localparam logic signed [VW-1:0] ONE_V = VW'(1) << FRAC;
    localparam logic [QP-1:0]        ONE_Q = QP'(1) << FRAC;

    function automatic logic signed [VW-1:0] sx(input logic signed [DW-1:0] x);
        sx = {{(VW-DW){x[DW-1]}}, x};
    endfunction

    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    logic [6:0] r_vld;
    logic [DLY2-1:0] r_pv;

    // Stage 1: estimates and off-diagonal terms.
    logic signed [VW-1:0] r1_est [4];
    logic signed [VW-1:0] r1_p   [6];
    // Stage 2: chosen vector.
    logic signed [VW-1:0] r2_v [4];
    logic                 r2_inv;
    // Stage 3: signs and magnitudes.
    logic [3:0]           r3_neg;
    logic [VW-1:0]        r3_mag [4];
    logic [VW-1:0]        r3_or;
    logic                 r3_inv;
    // Stage 4: leading one.
    logic [3:0]           r4_neg;
    logic [VW-1:0]        r4_mag [4];
    logic [MSBW-1:0]      r4_msb;
    logic                 r4_inv;
    // Stage 5: normalized magnitudes.
    logic [3:0]           r5_neg;
    t_lanes               r5_a;
    logic                 r5_inv;
    // Stage 6: squares.
    logic [3:0]           r6_neg;
    t_lanes               r6_a;
    logic [2*NW-1:0]      r6_sq [4];
    logic                 r6_inv;
    // Stage 7: sum of squares.
    logic [3:0]           r7_neg;
    t_lanes               r7_a;
    logic [SQ_IN-1:0]     r7_s;
    logic                 r7_inv;
    // Delay lines beside the root and divider pipelines.
    t_lanes               r_da   [SQ_STAGES];
    logic [3:0]           r_dneg [DLY2];
    logic                 r_dinv [DLY2];
    t_out                 r_out;

    logic [NRW-1:0] root;
    t_quo           quo;

    logic signed [VW-1:0] n2_v [4];
    logic                 n2_inv;
    logic [MSBW-1:0]      n4_msb;

    always_comb begin
        logic signed [VW-1:0] e [4];
        logic [1:0]           k;
        for (int i = 0; i < 4; i++) e[i] = r1_est[i];
        k = 2'd0;
        for (int i = 1; i < 4; i++) begin
            if (e[i] > e[k]) k = 2'(i);
        end
        n2_inv = !(e[k] > 0);
        case (k)
            2'd0: begin
                n2_v[0] = e[0];     n2_v[1] = r1_p[3]; n2_v[2] = r1_p[4]; n2_v[3] = r1_p[0];
            end
            2'd1: begin
                n2_v[0] = r1_p[3]; n2_v[1] = e[1];     n2_v[2] = r1_p[5]; n2_v[3] = r1_p[1];
            end
            2'd2: begin
                n2_v[0] = r1_p[4]; n2_v[1] = r1_p[5]; n2_v[2] = e[2];     n2_v[3] = r1_p[2];
            end
            default: begin
                n2_v[0] = r1_p[0]; n2_v[1] = r1_p[1]; n2_v[2] = r1_p[2]; n2_v[3] = e[3];
            end
        endcase
    end

    always_comb begin
        n4_msb = '0;
        for (int i = 0; i < VW; i++) begin
            if (r3_or[i]) n4_msb = MSBW'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_pv        <= '0;
            o_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[5:0], i_in_valid};
            r_pv        <= {r_pv[DLY2-2:0], r_vld[6]};
            o_out_valid <= r_pv[DLY2-1];
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [VW-1:0] tr;
        logic [VW+NW-1:0]     sh;
        logic [QP-1:0]        q;
        logic [QP-1:0]        qs [4];
        if (en) begin
            tr = sx(i_in_data.m00) + sx(i_in_data.m11) + sx(i_in_data.m22);
            r1_est[0] <= ONE_V + (sx(i_in_data.m00) <<< 1) - tr;
            r1_est[1] <= ONE_V + (sx(i_in_data.m11) <<< 1) - tr;
            r1_est[2] <= ONE_V + (sx(i_in_data.m22) <<< 1) - tr;
            r1_est[3] <= ONE_V + tr;
            r1_p[0]   <= sx(i_in_data.m12) - sx(i_in_data.m21);
            r1_p[1]   <= sx(i_in_data.m20) - sx(i_in_data.m02);
            r1_p[2]   <= sx(i_in_data.m01) - sx(i_in_data.m10);
            r1_p[3]   <= sx(i_in_data.m01) + sx(i_in_data.m10);
            r1_p[4]   <= sx(i_in_data.m20) + sx(i_in_data.m02);
            r1_p[5]   <= sx(i_in_data.m12) + sx(i_in_data.m21);

            r2_v   <= n2_v;
            r2_inv <= n2_inv;

            for (int i = 0; i < 4; i++) begin
                r3_neg[i] <= r2_v[i][VW-1];
                r3_mag[i] <= r2_v[i][VW-1] ? VW'(-r2_v[i]) : VW'(r2_v[i]);
            end
            // The leading one of the OR is the leading one of the largest magnitude.
            r3_or  <= (r2_v[0][VW-1] ? VW'(-r2_v[0]) : VW'(r2_v[0]))
                    | (r2_v[1][VW-1] ? VW'(-r2_v[1]) : VW'(r2_v[1]))
                    | (r2_v[2][VW-1] ? VW'(-r2_v[2]) : VW'(r2_v[2]))
                    | (r2_v[3][VW-1] ? VW'(-r2_v[3]) : VW'(r2_v[3]));
            r3_inv <= r2_inv;

            r4_neg <= r3_neg;
            r4_mag <= r3_mag;
            r4_msb <= n4_msb;
            r4_inv <= r3_inv;

            // Left shifts are exact; right shifts truncate toward zero.
            for (int i = 0; i < 4; i++) begin
                sh = ({{NW{1'b0}}, r4_mag[i]} << NORM_MSB) >> r4_msb;
                r5_a[i] <= sh[NW-1:0];
            end
            r5_neg <= r4_neg;
            r5_inv <= r4_inv;

            for (int i = 0; i < 4; i++) r6_sq[i] <= r5_a[i] * r5_a[i];
            r6_a   <= r5_a;
            r6_neg <= r5_neg;
            r6_inv <= r5_inv;

            r7_s   <= SQ_IN'(r6_sq[0]) + SQ_IN'(r6_sq[1])
                    + SQ_IN'(r6_sq[2]) + SQ_IN'(r6_sq[3]);
            r7_a   <= r6_a;
            r7_neg <= r6_neg;
            r7_inv <= r6_inv;

            r_da[0]   <= r7_a;
            r_dneg[0] <= r7_neg;
            r_dinv[0] <= r7_inv;
            for (int j = 1; j < SQ_STAGES; j++) r_da[j] <= r_da[j-1];
            for (int j = 1; j < DLY2; j++) begin
                r_dneg[j] <= r_dneg[j-1];
                r_dinv[j] <= r_dinv[j-1];
            end

            for (int i = 0; i < 4; i++) begin
                q = (quo[i] > ONE_Q) ? ONE_Q : quo[i];
                if (r_dinv[DLY2-1]) begin
                    qs[i] = '0;
                end else begin
                    qs[i] = r_dneg[DLY2-1][i] ? QP'(-q) : q;
                end
            end
            r_out.qx      <= qs[0][DW-1:0];
            r_out.qy      <= qs[1][DW-1:0];
            r_out.qz      <= qs[2][DW-1:0];
            r_out.qw      <= qs[3][DW-1:0];
            r_out.invalid <= r_dinv[DLY2-1];
        end
    end

    rmq_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_s    (r7_s),
        .o_root (root)
    );

    rmq_div u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_da[SQ_STAGES-1]),
        .i_n   (root),
        .o_q   (quo)
    );

    assign o_out_data = r_out;

endmodule
`default_nettype wire
